>>> rtl/weight_frame_deframer_unit_defines.svh
// Assertion macros used by the deframer parser RTL.
`ifndef WEIGHT_FRAME_DEFRAMER_UNIT_DEFINES_SVH
`define WEIGHT_FRAME_DEFRAMER_UNIT_DEFINES_SVH

`ifndef SYNTHESIS
`define WFD_ASSERT_IMPL(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");
`define WFD_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");
`else
`define WFD_ASSERT_IMPL(label, ante, cons)
`define WFD_ASSERT_NEXT(label, ante, cons)
`endif

`endif

>>> rtl/wfd_pkg.sv
package wfd_pkg;

  localparam int PhaseW = 4;

  localparam logic [PhaseW-1:0] PH_HUNT_A5 = 4'd0;
  localparam logic [PhaseW-1:0] PH_HUNT_5A = 4'd1;
  localparam logic [PhaseW-1:0] PH_TYPE0   = 4'd2;
  localparam logic [PhaseW-1:0] PH_TYPE1   = 4'd3;
  localparam logic [PhaseW-1:0] PH_LEN_HI  = 4'd4;
  localparam logic [PhaseW-1:0] PH_LEN_LO  = 4'd5;
  localparam logic [PhaseW-1:0] PH_PAYLOAD = 4'd6;
  localparam logic [PhaseW-1:0] PH_CRC0    = 4'd7;
  localparam logic [PhaseW-1:0] PH_CRC1    = 4'd8;

  localparam logic [7:0]  HDR_FIRST      = 8'hA5;
  localparam logic [7:0]  HDR_SECOND     = 8'h5A;
  localparam logic [7:0]  WEIGHT_TYPE    = 8'h01;
  localparam logic [15:0] MIN_WEIGHT_LEN = 16'd9;
  localparam logic [15:0] WEIGHT_BYTES   = 16'd4;

  typedef struct packed {
    logic        vld;
    logic [31:0] weight;
  } wfd_result_t;

endpackage

>>> rtl/wfd_parser.sv
`include "weight_frame_deframer_unit_defines.svh"

module wfd_parser (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_fire,
  input  logic [7:0]           rx_byte,
  output wfd_pkg::wfd_result_t res
);
  import wfd_pkg::*;

  logic [PhaseW-1:0] phase_r, phase_nxt;
  logic              is_weight_r, is_weight_nxt;
  logic [15:0]       payload_length_r, payload_length_nxt;
  logic [15:0]       byte_count_r, byte_count_nxt;
  logic [31:0]       weight_shift_r, weight_shift_nxt;
  logic [15:0]       len_full;
  logic [15:0]       count_inc;

  assign len_full  = {payload_length_r[15:8], rx_byte};
  assign count_inc = byte_count_r + 16'd1;

  always_comb begin
    phase_nxt          = phase_r;
    is_weight_nxt      = is_weight_r;
    payload_length_nxt = payload_length_r;
    byte_count_nxt     = byte_count_r;
    weight_shift_nxt   = weight_shift_r;
    res.vld            = 1'b0;
    res.weight         = weight_shift_r;
    unique case (phase_r)
      PH_HUNT_5A: begin
        if (rx_byte == HDR_SECOND) begin
          phase_nxt = PH_TYPE0;
        end else if (rx_byte == HDR_FIRST) begin
          phase_nxt = PH_HUNT_5A;
        end else begin
          phase_nxt = PH_HUNT_A5;
        end
      end
      PH_TYPE0: begin
        is_weight_nxt = (rx_byte == WEIGHT_TYPE);
        phase_nxt     = PH_TYPE1;
      end
      PH_TYPE1: begin
        is_weight_nxt = is_weight_r && (rx_byte == WEIGHT_TYPE);
        phase_nxt     = PH_LEN_HI;
      end
      PH_LEN_HI: begin
        payload_length_nxt = {rx_byte, 8'h00};
        phase_nxt          = PH_LEN_LO;
      end
      PH_LEN_LO: begin
        payload_length_nxt = len_full;
        byte_count_nxt     = 16'd0;
        weight_shift_nxt   = 32'd0;
        phase_nxt          = (len_full == 16'd0) ? PH_CRC0 : PH_PAYLOAD;
      end
      PH_PAYLOAD: begin
        if (byte_count_r < WEIGHT_BYTES) begin
          weight_shift_nxt = {weight_shift_r[23:0], rx_byte};
        end
        byte_count_nxt = count_inc;
        if (count_inc == payload_length_r) begin
          phase_nxt = PH_CRC0;
        end
      end
      PH_CRC0: begin
        phase_nxt = PH_CRC1;
      end
      PH_CRC1: begin
        res.vld   = in_fire && is_weight_r && (payload_length_r >= MIN_WEIGHT_LEN);
        phase_nxt = PH_HUNT_A5;
      end
      default: begin
        phase_nxt = (rx_byte == HDR_FIRST) ? PH_HUNT_5A : PH_HUNT_A5;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r          <= PH_HUNT_A5;
      is_weight_r      <= 1'b0;
      payload_length_r <= 16'd0;
      byte_count_r     <= 16'd0;
      weight_shift_r   <= 32'd0;
    end else if (in_fire) begin
      phase_r          <= phase_nxt;
      is_weight_r      <= is_weight_nxt;
      payload_length_r <= payload_length_nxt;
      byte_count_r     <= byte_count_nxt;
      weight_shift_r   <= weight_shift_nxt;
    end
  end

  `WFD_ASSERT_IMPL(a_res_only_crc1, res.vld, in_fire && (phase_r == PH_CRC1))
  `WFD_ASSERT_NEXT(a_crc1_to_hunt, in_fire && (phase_r == PH_CRC1), phase_r == PH_HUNT_A5)
  `WFD_ASSERT_IMPL(a_phase_range, 1'b1, phase_r <= PH_CRC1)
  `WFD_ASSERT_IMPL(a_count_below_len, phase_r == PH_PAYLOAD, byte_count_r < payload_length_r)

endmodule

>>> rtl/wfd_out_stage.sv
module wfd_out_stage (
  input  logic                 clk,
  input  logic                 rst_n,
  input  wfd_pkg::wfd_result_t res,
  output logic                 take_ready,
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic signed [31:0]   out_weight_tenths
);
  import wfd_pkg::*;

  logic        vld_r;
  logic [31:0] data_r;

  // free, or being drained this cycle
  assign take_ready = !vld_r || out_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else if (res.vld) begin
      vld_r <= 1'b1;
    end else if (out_ready) begin
      vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res.vld) begin
      data_r <= res.weight;
    end
  end

  assign out_valid         = vld_r;
  assign out_weight_tenths = $signed(data_r);

endmodule

>>> rtl/weight_frame_deframer_unit.sv
// Weight frame deframer: takes one received byte per cycle, locks onto
// A5 5A headers, walks type, length, payload and two unchecked CRC bytes,
// and for a 01 01 frame of length 9 or more delivers the signed big-endian
// weight (tenths of a gram) from the first four payload bytes. The result
// appears on out_* the cycle after the last CRC byte is accepted. Input
// throughput is one byte per cycle; in_ready drops only while the single
// output register holds a result that out_ready has not yet taken.
module weight_frame_deframer_unit (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [7:0]         in_rx_byte,
  output logic               out_valid,
  input  logic               out_ready,
  output logic signed [31:0] out_weight_tenths
);
  import wfd_pkg::*;

  wfd_result_t res;
  logic        in_fire;

  assign in_fire = in_valid && in_ready;

  wfd_parser u_parser (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_fire (in_fire),
    .rx_byte (in_rx_byte),
    .res     (res)
  );

  wfd_out_stage u_out (
    .clk               (clk),
    .rst_n             (rst_n),
    .res               (res),
    .take_ready        (in_ready),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_weight_tenths (out_weight_tenths)
  );

endmodule

>>> bench/testbench.sv
`timescale 1ns / 100ps

module testbench;
  import wfd_pkg::*;

  localparam int STALL_LIMIT = 4000;
  localparam int DRAIN_CYCLES = 10;

  class weight_scoreboard;
    logic [PhaseW-1:0]  phase;
    bit                 weight_type;
    logic [15:0]        frame_len;
    logic [15:0]        taken;
    logic [31:0]        weight_sr;
    logic signed [31:0] pending_weights[$];
    int                 errors;

    function new();
      phase       = PH_HUNT_A5;
      weight_type = 1'b0;
      frame_len   = '0;
      taken       = '0;
      weight_sr   = '0;
      errors      = 0;
    endfunction

    function void note_byte(logic [7:0] b);
      case (phase)
        PH_HUNT_5A: begin
          if (b == HDR_SECOND) phase = PH_TYPE0;
          else if (b == HDR_FIRST) phase = PH_HUNT_5A;
          else phase = PH_HUNT_A5;
        end
        PH_TYPE0: begin
          weight_type = (b == WEIGHT_TYPE);
          phase = PH_TYPE1;
        end
        PH_TYPE1: begin
          weight_type = weight_type && (b == WEIGHT_TYPE);
          phase = PH_LEN_HI;
        end
        PH_LEN_HI: begin
          frame_len = {b, 8'h00};
          phase = PH_LEN_LO;
        end
        PH_LEN_LO: begin
          frame_len = frame_len | {8'h00, b};
          taken     = '0;
          weight_sr = '0;
          phase     = (frame_len == 16'd0) ? PH_CRC0 : PH_PAYLOAD;
        end
        PH_PAYLOAD: begin
          if (taken < WEIGHT_BYTES) weight_sr = {weight_sr[23:0], b};
          taken = taken + 16'd1;
          if (taken == frame_len) phase = PH_CRC0;
        end
        PH_CRC0: phase = PH_CRC1;
        PH_CRC1: begin
          if (weight_type && frame_len >= MIN_WEIGHT_LEN) pending_weights.push_back(weight_sr);
          phase = PH_HUNT_A5;
        end
        default: phase = (b == HDR_FIRST) ? PH_HUNT_5A : PH_HUNT_A5;
      endcase
    endfunction

    function void check_weight(logic signed [31:0] got);
      logic signed [31:0] want;
      if (pending_weights.size() == 0) begin
        $display("%0t: unexpected weight transfer, expected none, actual %0d", $time, got);
        errors++;
      end else begin
        want = pending_weights.pop_front();
        if (got !== want) begin
          $display("%0t: weight_tenths mismatch, expected %0d, actual %0d", $time, want, got);
          errors++;
        end
      end
    endfunction
  endclass

  logic               clk = 1'b0;
  logic               rst_n = 1'b0;
  logic               in_valid = 1'b0;
  logic               in_ready;
  logic [7:0]         in_rx_byte = 8'h00;
  logic               out_valid;
  logic               out_ready = 1'b0;
  logic signed [31:0] out_weight_tenths;

  weight_scoreboard sb = new();
  int send_idle_pct = 8;
  int recv_idle_pct = 53;
  int frame_bytes_sent = 0;
  int quiet_cycles = 0;

  weight_frame_deframer_unit dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_rx_byte       (in_rx_byte),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_weight_tenths(out_weight_tenths)
  );

  always #6 clk = ~clk;

  always @(posedge clk) begin
    out_ready <= ($urandom_range(99) >= recv_idle_pct);
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if (in_valid && in_ready) sb.note_byte(in_rx_byte);
      if (out_valid && out_ready) sb.check_weight(out_weight_tenths);
      if ((in_valid && in_ready) || (out_valid && out_ready)) begin
        quiet_cycles <= 0;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
      if (quiet_cycles >= STALL_LIMIT) begin
        $display("TEST FAILED");
        $finish;
      end
    end
  end

  function automatic logic [7:0] data_byte();
    case ($urandom_range(7))
      0: return HDR_FIRST;
      1: return HDR_SECOND;
      default: return 8'($urandom_range(255));
    endcase
  endfunction

  function automatic logic [31:0] pick_weight();
    case ($urandom_range(7))
      0: return 32'h8000_0000;
      1: return 32'h7FFF_FFFF;
      2: return 32'h0000_0000;
      3: return 32'hFFFF_FFFF;
      4: return 32'($signed($urandom_range(20000)) - 10000);
      default: return $urandom;
    endcase
  endfunction

  task automatic send_byte(input logic [7:0] b, input bit in_frame);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid   <= 1'b1;
    in_rx_byte <= b;
    do @(posedge clk); while (!in_ready);
    if (in_frame) frame_bytes_sent++;
  endtask

  task automatic send_frame(input logic [7:0] t0, input logic [7:0] t1,
                            input logic [15:0] len, input logic [31:0] w);
    send_byte(HDR_FIRST, 1'b1);
    send_byte(HDR_SECOND, 1'b1);
    send_byte(t0, 1'b1);
    send_byte(t1, 1'b1);
    send_byte(len[15:8], 1'b1);
    send_byte(len[7:0], 1'b1);
    for (int i = 0; i < int'(len); i++) begin
      send_byte((i < 4) ? w[31 - 8 * i -: 8] : data_byte(), 1'b1);
    end
    send_byte(data_byte(), 1'b1);
    send_byte(data_byte(), 1'b1);
  endtask

  task automatic run_directed();
    // repeated header byte keeps the hunt armed
    send_byte(HDR_FIRST, 1'b0);
    send_byte(HDR_FIRST, 1'b0);
    send_frame(WEIGHT_TYPE, WEIGHT_TYPE, 16'd9, 32'h0000_0C8E);
    // armed hunt broken by another byte
    send_byte(HDR_FIRST, 1'b0);
    send_byte(8'h00, 1'b0);
    send_frame(WEIGHT_TYPE, WEIGHT_TYPE, 16'd12, 32'h8000_0000);
    send_frame(WEIGHT_TYPE, WEIGHT_TYPE, 16'd0, 32'h0);
    send_frame(WEIGHT_TYPE, WEIGHT_TYPE, 16'd8, 32'h1234_5678);
    send_frame(WEIGHT_TYPE, 8'h02, 16'd9, 32'h1111_1111);
    send_frame(8'h02, WEIGHT_TYPE, 16'd9, 32'h2222_2222);
    send_frame(WEIGHT_TYPE, WEIGHT_TYPE, 16'd10, 32'h7FFF_FFFF);
    send_frame(WEIGHT_TYPE, WEIGHT_TYPE, 16'd9, 32'hFFFF_FFFF);
    send_frame(WEIGHT_TYPE, WEIGHT_TYPE, 16'd9, 32'h0000_0000);
    send_frame(8'hFF, 8'hFF, 16'd3, 32'hA55A_A55A);
    send_frame(WEIGHT_TYPE, WEIGHT_TYPE, 16'h0100, 32'hFFFF_FC18);
  endtask

  task automatic run_random(input int n_items);
    int stop_at;
    int pick;
    int n;
    logic [15:0] len;
    stop_at = frame_bytes_sent + n_items;
    while (frame_bytes_sent < stop_at) begin
      pick = $urandom_range(99);
      if (pick < 65) begin
        len = ($urandom_range(4) == 0) ? 16'($urandom_range(8)) : 16'($urandom_range(16, 9));
        send_frame(WEIGHT_TYPE, WEIGHT_TYPE, len, pick_weight());
      end else if (pick < 77) begin
        send_frame(data_byte(), data_byte(), 16'($urandom_range(16)), pick_weight());
      end else if (pick < 87) begin
        n = $urandom_range(6, 1);
        repeat (n) send_byte(data_byte(), 1'b0);
      end else if (pick < 97) begin
        send_byte(HDR_FIRST, 1'b0);
        if ($urandom_range(1)) send_byte(HDR_FIRST, 1'b0);
        send_byte(8'($urandom_range(255)), 1'b0);
      end else if (pick < 99) begin
        send_frame(WEIGHT_TYPE, WEIGHT_TYPE, 16'($urandom_range(400, 256)), pick_weight());
      end else begin
        send_frame(8'($urandom_range(255)), 8'($urandom_range(255)),
                   16'($urandom_range(15, 9)), $urandom);
      end
    end
  endtask

  initial begin
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    send_idle_pct = 8;
    recv_idle_pct = 53;
    run_directed();
    run_random(450);

    send_idle_pct = 53;
    recv_idle_pct = 8;
    run_random(550);

    send_idle_pct = 0;
    recv_idle_pct = 0;
    run_random(550);

    in_valid <= 1'b0;
    while (sb.pending_weights.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (sb.errors == 0 && sb.pending_weights.size() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

>>> filelist.f
+incdir+rtl
rtl/wfd_pkg.sv
rtl/wfd_parser.sv
rtl/wfd_out_stage.sv
rtl/weight_frame_deframer_unit.sv
bench/testbench.sv
